FILE: design/bmp_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types and constants of the binomial coefficient mod prime core.
// ----------------------------------------------------------------------------
`default_nettype none

package bmp_pkg;

  localparam int FIELD_W = 17;  // n and k field width
  localparam int VAL_W   = 30;  // residue width

  localparam logic [VAL_W-1:0] PRIME_MOD  = 30'd1000000009;
  localparam logic [VAL_W-1:0] FERMAT_EXP = 30'd1000000007;

  // modular multiplier: two bits of the multiplier per step
  localparam int MUL_STEPS = VAL_W / 2;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);
  localparam int RED_W     = VAL_W + 3;

  // multiples of the prime used by the per-step reduction
  localparam logic [RED_W-1:0] PRIME_MULT [0:6] = '{
    33'd0,
    33'd1000000009,
    33'd2000000018,
    33'd3000000027,
    33'd4000000036,
    33'd5000000045,
    33'd6000000054
  };

  typedef enum logic [11:0] {
    S_FILL_WR  = 12'b0000_0000_0001,
    S_FILL_MUL = 12'b0000_0000_0010,
    S_IDLE     = 12'b0000_0000_0100,
    S_RD_N     = 12'b0000_0000_1000,
    S_RD_K     = 12'b0000_0001_0000,
    S_RD_D     = 12'b0000_0010_0000,
    S_LD_D     = 12'b0000_0100_0000,
    S_MUL_DEN  = 12'b0000_1000_0000,
    S_INV_CHK  = 12'b0001_0000_0000,
    S_INV_ACC  = 12'b0010_0000_0000,
    S_INV_SQ   = 12'b0100_0000_0000,
    S_MUL_FIN  = 12'b1000_0000_0000
  } bmp_state_t;

endpackage

`default_nettype wire

FILE: design/binomial_mod_prime_core.sv
// ----------------------------------------------------------------------------
// binomial_mod_prime_core
// C(n,k) mod 1000000009 from a factorial table held in a synchronous memory,
// with Fermat inversion on a shared iterative modular multiplier.
// ----------------------------------------------------------------------------
// After reset the core fills its factorial table, one modular product per
// entry, and holds busy high until the fill is finished.
// A transaction is taken when start is high and busy is low. When n is below
// k, or n is beyond the table, the zero result appears on the next cycle.
// Otherwise the core reads three table entries over one read port and runs
// 48 dependent modular products (denominator, 30 squarings, 16 accumulates,
// final product) on one multiplier that retires two bits per cycle.
// The result is shown for exactly one cycle with out_valid; the receiver
// cannot stall it, and busy is low in that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_mod_prime_core #(
  parameter int TABLE_DEPTH = 131072
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [bmp_pkg::FIELD_W-1:0] in_n_total,
  input  wire logic [bmp_pkg::FIELD_W-1:0] in_k_chosen,
  output logic                            out_valid,
  output logic [bmp_pkg::VAL_W-1:0]       out_binomial_value
);

  import bmp_pkg::*;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CMP_W  = ((ADDR_W > FIELD_W) ? ADDR_W : FIELD_W) + 1;
  localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [CMP_W-1:0]  DEPTH_CMP = CMP_W'(TABLE_DEPTH);
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_STEPS - 1);

  // factorial table
  logic [VAL_W-1:0] fact_mem [TABLE_DEPTH];
  logic             mem_we;
  logic [ADDR_W-1:0] rd_addr;
  logic [VAL_W-1:0] rd_data_r;

  bmp_state_t state_r, state_nxt;
  logic              fill_done_r, fill_done_nxt;
  logic [ADDR_W-1:0] fill_idx_r, fill_idx_nxt;
  logic [VAL_W-1:0]  fact_r, fact_nxt;
  logic [CMP_W-1:0]  n_r, n_nxt, k_r, k_nxt;
  logic [CMP_W-1:0]  nk_diff;
  logic [VAL_W-1:0]  fn_r, fn_nxt;
  logic [VAL_W-1:0]  base_r, base_nxt;
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic [VAL_W-1:0]  exp_r, exp_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_val_r, out_val_nxt;

  // shared modular multiplier
  logic                 mul_go;
  logic [VAL_W-1:0]     mul_op_a, mul_op_b;
  logic [VAL_W-1:0]     mul_a_r, mul_b_r, mul_acc_r;
  logic [VAL_W+1:0]     mul_a3_r;
  logic [MUL_CNT_W-1:0] mul_cnt_r;
  logic                 mul_busy_r, mul_done_r;
  logic [VAL_W+1:0]     mul_pp;
  logic [RED_W-1:0]     mul_sum, mul_sub, mul_red;

  logic [CMP_W-1:0] in_n_ext, in_k_ext;
  logic             accept;

  assign in_n_ext = CMP_W'(in_n_total);
  assign in_k_ext = CMP_W'(in_k_chosen);
  assign nk_diff  = n_r - k_r;
  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;

  assign out_valid          = out_valid_r;
  assign out_binomial_value = out_val_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fact_mem[fill_idx_r] <= fact_r;
    end
    rd_data_r <= fact_mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    fill_done_nxt = fill_done_r;
    fill_idx_nxt  = fill_idx_r;
    fact_nxt      = fact_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    fn_nxt        = fn_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    exp_nxt       = exp_r;
    out_valid_nxt = 1'b0;
    out_val_nxt   = out_val_r;
    mul_go        = 1'b0;
    mul_op_a      = '0;
    mul_op_b      = '0;
    mem_we        = 1'b0;
    rd_addr       = '0;

    unique case (state_r)
      S_FILL_WR: begin
        mem_we = 1'b1;
        if (fill_idx_r == LAST_IDX) begin
          fill_done_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          fill_idx_nxt = fill_idx_r + 1'b1;
          mul_go       = 1'b1;
          mul_op_a     = fact_r;
          mul_op_b     = VAL_W'(fill_idx_nxt);
          state_nxt    = S_FILL_MUL;
        end
      end
      S_FILL_MUL: begin
        if (mul_done_r) begin
          fact_nxt  = mul_acc_r;
          state_nxt = S_FILL_WR;
        end
      end
      S_IDLE: begin
        if (start) begin
          n_nxt = in_n_ext;
          k_nxt = in_k_ext;
          if ((in_n_ext < in_k_ext) || (in_n_ext >= DEPTH_CMP)) begin
            out_valid_nxt = 1'b1;
            out_val_nxt   = '0;
          end else begin
            state_nxt = S_RD_N;
          end
        end
      end
      S_RD_N: begin
        rd_addr   = n_r[ADDR_W-1:0];
        state_nxt = S_RD_K;
      end
      S_RD_K: begin
        rd_addr   = k_r[ADDR_W-1:0];
        fn_nxt    = rd_data_r;
        state_nxt = S_RD_D;
      end
      S_RD_D: begin
        rd_addr   = nk_diff[ADDR_W-1:0];
        base_nxt  = rd_data_r;
        state_nxt = S_LD_D;
      end
      S_LD_D: begin
        mul_go    = 1'b1;
        mul_op_a  = base_r;
        mul_op_b  = rd_data_r;
        state_nxt = S_MUL_DEN;
      end
      S_MUL_DEN: begin
        if (mul_done_r) begin
          base_nxt  = mul_acc_r;
          acc_nxt   = VAL_W'(1);
          exp_nxt   = FERMAT_EXP;
          state_nxt = S_INV_CHK;
        end
      end
      S_INV_CHK: begin
        mul_go = 1'b1;
        if (exp_r == '0) begin
          mul_op_a  = fn_r;
          mul_op_b  = acc_r;
          state_nxt = S_MUL_FIN;
        end else if (exp_r[0]) begin
          mul_op_a  = acc_r;
          mul_op_b  = base_r;
          state_nxt = S_INV_ACC;
        end else begin
          mul_op_a  = base_r;
          mul_op_b  = base_r;
          state_nxt = S_INV_SQ;
        end
      end
      S_INV_ACC: begin
        if (mul_done_r) begin
          acc_nxt   = mul_acc_r;
          mul_go    = 1'b1;
          mul_op_a  = base_r;
          mul_op_b  = base_r;
          state_nxt = S_INV_SQ;
        end
      end
      S_INV_SQ: begin
        if (mul_done_r) begin
          base_nxt  = mul_acc_r;
          exp_nxt   = exp_r >> 1;
          state_nxt = S_INV_CHK;
        end
      end
      S_MUL_FIN: begin
        if (mul_done_r) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = mul_acc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL_WR;
      fill_done_r <= 1'b0;
      fill_idx_r  <= '0;
      fact_r      <= VAL_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_done_r <= fill_done_nxt;
      fill_idx_r  <= fill_idx_nxt;
      fact_r      <= fact_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    k_r       <= k_nxt;
    fn_r      <= fn_nxt;
    base_r    <= base_nxt;
    acc_r     <= acc_nxt;
    exp_r     <= exp_nxt;
    out_val_r <= out_val_nxt;
  end

  // one multiplier digit per step: acc = 4*acc + a*d, then reduce below p
  always_comb begin
    case (mul_b_r[VAL_W-1 -: 2])
      2'd0:    mul_pp = '0;
      2'd1:    mul_pp = {2'b00, mul_a_r};
      2'd2:    mul_pp = {1'b0, mul_a_r, 1'b0};
      default: mul_pp = mul_a3_r;
    endcase
    mul_sum = {1'b0, mul_acc_r, 2'b00} + {1'b0, mul_pp};
    mul_sub = '0;
    // sum stays below 7p, so the largest multiple not above it is enough
    for (int m = 1; m <= 6; m++) begin
      if (mul_sum >= PRIME_MULT[m]) begin
        mul_sub = PRIME_MULT[m];
      end
    end
    mul_red = mul_sum - mul_sub;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_done_r <= 1'b0;
      mul_cnt_r  <= '0;
    end else begin
      mul_done_r <= mul_busy_r && (mul_cnt_r == MUL_LAST);
      if (mul_go) begin
        mul_busy_r <= 1'b1;
        mul_cnt_r  <= '0;
      end else if (mul_busy_r) begin
        mul_cnt_r <= mul_cnt_r + 1'b1;
        if (mul_cnt_r == MUL_LAST) begin
          mul_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_go) begin
      mul_a_r   <= mul_op_a;
      mul_a3_r  <= {2'b00, mul_op_a} + {1'b0, mul_op_a, 1'b0};
      mul_b_r   <= mul_op_b;
      mul_acc_r <= '0;
    end else if (mul_busy_r) begin
      mul_acc_r <= mul_red[VAL_W-1:0];
      mul_b_r   <= mul_b_r << 2;
    end
  end

  a_fill_holds_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !fill_done_r |-> busy)
    else $error("transaction window open before the table fill finished");

  a_zero_result_next: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_n_total < in_k_chosen)) |=>
      (out_valid && (out_binomial_value == '0)))
    else $error("n below k did not give a zero result on the next cycle");

  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_binomial_value < PRIME_MOD))
    else $error("result not reduced below the prime");

  a_mul_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    mul_busy_r |-> (mul_acc_r < PRIME_MOD))
    else $error("multiplier accumulator escaped its reduction range");

  a_mul_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done_r |-> ($past(mul_busy_r) && !mul_busy_r))
    else $error("multiplier done without a finished product");

endmodule

`default_nettype wire
